[rtl/eegfs_pkg.sv]
// ----------------------------------------------------------------------------
// eegfs_pkg
// Shared types, codes and mode tables for the EEG frame deframer.
// ----------------------------------------------------------------------------
package eegfs_pkg;

  localparam logic [31:0] SYNC_WORD   = 32'hFFFF_FF00;
  localparam logic [3:0]  MODE_MAX    = 4'd8;
  localparam logic [8:0]  REQ_CH_RST  = 9'd64;

  // Word kind codes on the result channel
  typedef enum logic [2:0] {
    KIND_SYNC    = 3'd0,
    KIND_STATUS  = 3'd1,
    KIND_EEG     = 3'd2,
    KIND_SENSOR  = 3'd3,
    KIND_DISCARD = 3'd4
  } kind_e;

  // Frame phase, one-hot
  typedef enum logic [3:0] {
    PH_WAIT_SYNC   = 4'b0001,
    PH_WAIT_STATUS = 4'b0010,
    PH_RUN         = 4'b0100,
    PH_ERROR       = 4'b1000
  } phase_e;

  // One word held in the input register
  typedef struct packed {
    logic        valid;
    logic [31:0] data;
  } word_t;

  // One tagged result
  typedef struct packed {
    kind_e       kind;
    logic [8:0]  chan_idx;
    logic [31:0] value;
    logic        last;
    logic        err;
    logic        cfg;
    logic [3:0]  mode;
    logic        mk2;
    logic [14:0] rate;
    logic [9:0]  eeg_cnt;
    logic [6:0]  sensor_cnt;
  } result_t;

  // Frame length in words per model and speed mode
  function automatic logic [9:0] len_lut(input logic mk, input logic [3:0] mode);
    logic [9:0] len;
    case (mode)
      4'd0:    len = mk ? 10'd610 : 10'd258;
      4'd1:    len = mk ? 10'd610 : 10'd130;
      4'd2:    len = mk ? 10'd610 : 10'd66;
      4'd3:    len = mk ? 10'd610 : 10'd34;
      4'd4:    len = mk ? 10'd282 : 10'd258;
      4'd5:    len = mk ? 10'd154 : 10'd130;
      4'd6:    len = mk ? 10'd90  : 10'd66;
      4'd7:    len = mk ? 10'd58  : 10'd34;
      4'd8:    len = mk ? 10'd314 : 10'd290;
      default: len = 10'd0;
    endcase
    return len;
  endfunction

  // EEG channels per frame per model and speed mode
  function automatic logic [9:0] eeg_lut(input logic mk, input logic [3:0] mode);
    logic [9:0] cnt;
    case (mode)
      4'd0:    cnt = mk ? 10'd512 : 10'd256;
      4'd1:    cnt = mk ? 10'd512 : 10'd128;
      4'd2:    cnt = mk ? 10'd512 : 10'd64;
      4'd3:    cnt = mk ? 10'd512 : 10'd32;
      4'd4:    cnt = mk ? 10'd256 : 10'd232;
      4'd5:    cnt = mk ? 10'd128 : 10'd104;
      4'd6:    cnt = mk ? 10'd64  : 10'd40;
      4'd7:    cnt = mk ? 10'd32  : 10'd8;
      4'd8:    cnt = mk ? 10'd280 : 10'd256;
      default: cnt = 10'd0;
    endcase
    return cnt;
  endfunction

  // Sample rate in Hz per model and speed mode; out-of-range modes read as mode 0
  function automatic logic [14:0] rate_lut(input logic mk, input logic [3:0] mode);
    logic [14:0] rate;
    case (mode)
      4'd1:    rate = mk ? 15'd2048  : 15'd4096;
      4'd2:    rate = mk ? 15'd2048  : 15'd8192;
      4'd3:    rate = mk ? 15'd2048  : 15'd16384;
      4'd4:    rate = 15'd2048;
      4'd5:    rate = 15'd4096;
      4'd6:    rate = 15'd8192;
      4'd7:    rate = 15'd16384;
      default: rate = 15'd2048;
    endcase
    return rate;
  endfunction

endpackage

[rtl/eegfs_in_reg.sv]
// ----------------------------------------------------------------------------
// eegfs_in_reg
// Input word register; stalls while it holds a word that the result side does not take.
// ----------------------------------------------------------------------------
module eegfs_in_reg import eegfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic        take_i,
  output word_t       word_o
);

  logic        valid_q, valid_d;
  logic [31:0] data_q;
  logic        load;

  // Stall only when a held word cannot move on this cycle
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the word on acceptance
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_word_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

[rtl/eegfs_tagger.sv]
// ----------------------------------------------------------------------------
// eegfs_tagger
// Frame state, word tagging and the result register.
// ----------------------------------------------------------------------------
module eegfs_tagger import eegfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  word_t      word_i,
  output logic       take_o,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [9:0]  pos_q, pos_d;
  logic [9:0]  len_q, len_d;
  logic [9:0]  eeg_q, eeg_d;
  logic [3:0]  mode_q, mode_d;
  logic        mk_q, mk_d;
  logic        err_q, err_d;
  logic [8:0]  req_q;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;
  logic        step;
  logic [3:0]  st_mode;
  logic [10:0] eeg_end;
  logic [9:0]  cap;

  // Take a word whenever the result register is free or draining
  assign take_o      = ~res_valid_q | ~res_stall_i;
  assign step        = word_i.valid & take_o;
  assign res_valid_d = step | (res_valid_q & res_stall_i);

  assign st_mode = {word_i.data[29], word_i.data[27:25]};
  assign eeg_end = 11'd2 + {1'b0, eeg_q};

  // Advance the frame state and tag the word
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    eeg_d   = eeg_q;
    mode_d  = mode_q;
    mk_d    = mk_q;
    err_d   = err_q;
    res_d   = '0;
    res_d.kind  = KIND_DISCARD;
    res_d.value = word_i.data;

    case (phase_q)
      PH_WAIT_SYNC: begin
        if (word_i.data == SYNC_WORD) begin
          res_d.kind = KIND_SYNC;
          pos_d      = 10'd1;
          phase_d    = PH_WAIT_STATUS;
        end else begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end
      end
      PH_WAIT_STATUS: begin
        if (st_mode > MODE_MAX) begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          mode_d     = st_mode;
          mk_d       = word_i.data[31];
          len_d      = len_lut(word_i.data[31], st_mode);
          eeg_d      = eeg_lut(word_i.data[31], st_mode);
          res_d.kind = KIND_STATUS;
          pos_d      = 10'd2;
          phase_d    = PH_RUN;
        end
      end
      PH_RUN: begin
        if (pos_q == 10'd0 && word_i.data != SYNC_WORD) begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          if (pos_q == 10'd0) begin
            res_d.kind = KIND_SYNC;
          end else if (pos_q == 10'd1) begin
            res_d.kind = KIND_STATUS;
          end else if ({1'b0, pos_q} < eeg_end) begin
            res_d.kind     = KIND_EEG;
            res_d.chan_idx = 9'(pos_q - 10'd2);
          end else begin
            res_d.kind     = KIND_SENSOR;
            res_d.chan_idx = 9'(pos_q - 10'd2 - eeg_q);
          end
          if (({1'b0, pos_q} + 11'd1) >= {1'b0, len_q}) begin
            res_d.last = 1'b1;
            pos_d      = 10'd0;
          end else begin
            pos_d = pos_q + 10'd1;
          end
        end
      end
      PH_ERROR: begin
        err_d = 1'b1;
      end
      default: begin
        phase_d = PH_ERROR;
        err_d   = 1'b1;
      end
    endcase

    // Report decoded settings from the updated state
    cap        = ({1'b0, req_q} < eeg_d) ? {1'b0, req_q} : eeg_d;
    res_d.err  = err_d;
    res_d.cfg  = (len_d != 10'd0);
    if (res_d.cfg) begin
      res_d.mode       = mode_d;
      res_d.mk2        = mk_d;
      res_d.rate       = rate_lut(mk_d, mode_d);
      res_d.eeg_cnt    = cap;
      res_d.sensor_cnt = 7'(len_d - eeg_d - 10'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_SYNC;
      pos_q       <= '0;
      len_q       <= '0;
      eeg_q       <= '0;
      mode_q      <= '0;
      mk_q        <= 1'b0;
      err_q       <= 1'b0;
      req_q       <= REQ_CH_RST;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        req_q <= cfg_wdata_i;
      end
      if (step) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
        eeg_q   <= eeg_d;
        mode_q  <= mode_d;
        mk_q    <= mk_d;
        err_q   <= err_d;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/eeg_frame_sync_deframer.sv]
// ----------------------------------------------------------------------------
// eeg_frame_sync_deframer
// Tags each word of an EEG amplifier stream by frame position.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one 32-bit stream word per
// handshake. Output channel: out_valid_o / out_stall_i carry one tagged word
// per input word: its kind, channel index, the raw value, a frame-end mark
// and the decoded stream settings.
// A word accepted into the input register reaches the outputs when the result
// register loads it, which waits while the receiver stalls. Throughput is one
// word per cycle while the receiver does not stall; the frame state update
// between the two registers sets that rate.
// When the receiver stalls, the result holds and the input register takes a
// word only while empty; in_stall_o is high while it holds a word.
// Reset (rst_ni low) empties both registers, returns to waiting for the
// first sync word, clears the error flag and loads a channel request of 64.
// The channel request is written through cfg_we_i / cfg_wdata_i; the user must write it only
// while the stream is idle, which the block does not enforce. It only caps the reported EEG count.
// ----------------------------------------------------------------------------
module eeg_frame_sync_deframer import eegfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  word_kind_o,
  output logic [8:0]  channel_index_o,
  output logic [31:0] word_value_o,
  output logic        frame_last_o,
  output logic        sync_error_o,
  output logic        configured_o,
  output logic [3:0]  speed_mode_o,
  output logic        model_mk2_o,
  output logic [14:0] sample_rate_o,
  output logic [9:0]  eeg_count_o,
  output logic [6:0]  sensor_count_o
);

  word_t   word;
  logic    take;
  result_t res;

  eegfs_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_word_i (data_word_i),
    .take_i      (take),
    .word_o      (word)
  );

  eegfs_tagger u_tagger (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (word),
    .take_o      (take),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Spread the result onto its ports
  assign word_kind_o     = res.kind;
  assign channel_index_o = res.chan_idx;
  assign word_value_o    = res.value;
  assign frame_last_o    = res.last;
  assign sync_error_o    = res.err;
  assign configured_o    = res.cfg;
  assign speed_mode_o    = res.mode;
  assign model_mk2_o     = res.mk2;
  assign sample_rate_o   = res.rate;
  assign eeg_count_o     = res.eeg_cnt;
  assign sensor_count_o  = res.sensor_cnt;

endmodule

[rtl/eegfs_checker.sv]
// ----------------------------------------------------------------------------
// eegfs_checker
// Port-level checks for the EEG frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module eegfs_checker import eegfs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  word_kind_o,
  input logic [8:0]  channel_index_o,
  input logic [31:0] word_value_o,
  input logic        frame_last_o,
  input logic        sync_error_o,
  input logic        configured_o,
  input logic [3:0]  speed_mode_o,
  input logic [14:0] sample_rate_o,
  input logic [9:0]  eeg_count_o,
  input logic [6:0]  sensor_count_o
);

  // Once in error, every word is discarded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sync_error_o |-> word_kind_o == KIND_DISCARD)
    else $error("word tagged while in error");

  // A discarded word carries the error and no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_kind_o == KIND_DISCARD
      |-> sync_error_o && !frame_last_o && channel_index_o == 9'd0)
    else $error("discarded word with bad tagging");

  // Before decode, the mode, rate and counts read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !configured_o
      |-> speed_mode_o == 4'd0 && sample_rate_o == 15'd0
          && eeg_count_o == 10'd0 && sensor_count_o == 7'd0)
    else $error("settings reported before decode");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_value_o)
      && $stable(word_kind_o))
    else $error("stalled result changed");

endmodule

bind eeg_frame_sync_deframer eegfs_checker u_eegfs_checker (.*);
